FILE: hw/rtl/ecpm_pkg.sv
// Package for the energy counter power meter: item types, the per-domain
// state word, configuration register indexes and fixed constants.
// No dependencies.
package ecpm_pkg;

  localparam int DOMAINS_DEF = 4;

  localparam int ENERGY_W = 40;
  localparam int ELAPSED_W = 16;
  localparam int MJ_W = 32;
  localparam int TOTAL_W = 48;
  localparam int POWER_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE0 = 3'd1;

  localparam logic [ELAPSED_W-1:0] UJ_PER_MJ = 16'd1000;

  typedef struct packed {
    logic [1:0]           domain;
    logic [ENERGY_W-1:0]  raw_uj;
    logic [ELAPSED_W-1:0] elapsed_s;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         domain_out;
    logic               updated;
    logic [POWER_W-1:0] power_mw;
    logic [POWER_W-1:0] max_power_mw;
    logic [POWER_W-1:0] min_power_mw;
    logic [TOTAL_W-1:0] energy_total_mj;
  } out_item_t;

  typedef struct packed {
    logic [MJ_W-1:0]    last_mj;
    logic [TOTAL_W-1:0] wrapped_mj;
    logic               armed;
    logic [POWER_W-1:0] power;
    logic [POWER_W-1:0] pw_max;
    logic [POWER_W-1:0] pw_min;
  } entry_t;

endpackage

FILE: hw/rtl/ecpm_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
// Standalone; used by the energy counter power meter top level.
module ecpm_div #(
  parameter int DW = 40,
  parameter int VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o
);

  localparam int IT = (DW + 1) / 2;
  localparam int PW = 2 * IT;
  localparam int CW = $clog2(IT + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] sh_q, sh_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;

  logic [VW:0]   t1, t2, r1, r2;
  logic          ge1, ge2;

  always_comb begin
    t1 = {rem_q, sh_q[PW-1]};
    ge1 = t1 >= {1'b0, dvs_q};
    r1 = ge1 ? t1 - {1'b0, dvs_q} : t1;
    t2 = {r1[VW-1:0], sh_q[PW-2]};
    ge2 = t2 >= {1'b0, dvs_q};
    r2 = ge2 ? t2 - {1'b0, dvs_q} : t2;

    busy_d = busy_q;
    cnt_d = cnt_q;
    sh_d = sh_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = CW'(IT);
      sh_d = PW'(dividend_i);
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (busy_q) begin
      sh_d = {sh_q[PW-3:0], ge1, ge2};
      rem_d = r2[VW-1:0];
      cnt_d = cnt_q - 1'b1;
      busy_d = cnt_q != CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quotient_o = sh_q[DW-1:0];

endmodule

FILE: hw/rtl/energy_counter_power_meter.sv
// Energy counter power meter top level: configuration registers, per-domain
// state memory, control sequencer, reciprocal conversion and one ecpm_div.
// Depends on ecpm_pkg and ecpm_div.
//
// Usage: each input item carries a domain, a raw energy reading in microjoules
// and the seconds elapsed. Each item yields exactly one result item with the
// domain's power, running maximum and minimum power and cumulative energy.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. Configuration is a plain write port (enable, index, data):
// index 0 is the measurement enable, indexes 1 to DOMAINS the domain ranges.
// Steps: an item that computes a new power passes the memory read together
// with the first multiply stage, the second multiply stage of the divisions
// by 1000, delta arithmetic, the power division and the write back before it
// is in the output register. An updating item without a power division skips
// that division, and a non-updating item (disabled, zero elapsed or unknown
// domain) goes from the memory read straight to the final step. One item is
// in work at a time; the next is accepted once the sequencer is idle again
// after the result is loaded. Reset clears the configuration and marks all
// domain state as zero through per-domain valid bits. A stalled output holds
// its result and the following item waits in the final step until the
// register frees up.
module energy_counter_power_meter #(
  parameter int DOMAINS = ecpm_pkg::DOMAINS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ecpm_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ecpm_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ecpm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ecpm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int AW = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
  localparam logic [2:0] DOM_LIMIT = 3'(DOMAINS);
  localparam int EW = ecpm_pkg::ENERGY_W;
  localparam int MW = ecpm_pkg::MJ_W;
  localparam int TW = ecpm_pkg::TOTAL_W;
  localparam int PWR = ecpm_pkg::POWER_W;
  localparam int YW = EW - 3;
  localparam logic [37:0] RECIP = 38'd140737488356;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_CDIV = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_PDIV = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  // Configuration registers.
  logic          enable_q;
  logic [EW-1:0] range_q [DOMAINS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      for (int i = 0; i < DOMAINS; i++) begin
        range_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ecpm_pkg::CFG_ENABLE) begin
        enable_q <= cfg_data_i[0];
      end
      for (int i = 0; i < DOMAINS; i++) begin
        if (cfg_idx_i == ecpm_pkg::CFG_RANGE0 + ecpm_pkg::CFG_IDX_W'(i)) begin
          range_q[i] <= cfg_data_i[EW-1:0];
        end
      end
    end
  end

  // Sequencer and item registers.
  logic [2:0]         state_q, state_d;
  ecpm_pkg::in_item_t item_q;
  logic               upd_q, dom_ok_q;
  logic               out_valid_q;
  ecpm_pkg::out_item_t out_q;

  logic in_acc, dom_ok_in, upd_in, fin_go;
  logic [AW-1:0] in_addr, item_addr;

  assign in_acc = in_valid_i && (state_q == ST_IDLE);
  assign dom_ok_in = {1'b0, in_data_i.domain} < DOM_LIMIT;
  assign upd_in = enable_q && (in_data_i.elapsed_s != '0) && dom_ok_in;
  assign in_addr = in_data_i.domain[AW-1:0];
  assign item_addr = item_q.domain[AW-1:0];
  assign fin_go = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  // State memory with registered read and per-entry valid bits.
  ecpm_pkg::entry_t mem [DOMAINS];
  ecpm_pkg::entry_t rd_q, entry, wr_entry;
  logic [DOMAINS-1:0] mem_vld_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (fin_go && upd_q) begin
      mem[item_addr] <= wr_entry;
    end
    if (in_acc) begin
      rd_q <= mem[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (fin_go && upd_q) begin
        mem_vld_q[item_addr] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_q <= mem_vld_q[in_addr];
      end
    end
  end

  assign entry = rd_vld_q ? rd_q : '0;

  // The reading and the range are divided by 1000 as x / 8 / 125 through a
  // reciprocal multiplication in two stages, split into products of at most
  // 32 by 32 bits. Entry 0 converts the reading, entry 1 the range.
  logic [EW-1:0] range_cur;
  logic [YW-1:0] cv_y [2];
  logic [63:0]   cv_p00_q [2];
  logic [38:0]   cv_pmid_q [2];
  logic [10:0]   cv_p11_q [2];
  logic [74:0]   cv_sum [2];
  logic [MW-1:0] mj_q [2];

  assign range_cur = dom_ok_q ? range_q[item_addr] : '0;
  assign cv_y[0] = item_q.raw_uj[EW-1:3];
  assign cv_y[1] = range_cur[EW-1:3];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      cv_sum[k] = 75'(cv_p00_q[k]) + {4'd0, cv_pmid_q[k], 32'd0} + {cv_p11_q[k], 64'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 2; k++) begin
      cv_p00_q[k] <= 64'(cv_y[k][31:0]) * 64'(RECIP[31:0]);
      cv_pmid_q[k] <= 39'(cv_y[k][31:0]) * 39'(RECIP[37:32])
                    + 39'(cv_y[k][YW-1:32]) * 39'(RECIP[31:0]);
      cv_p11_q[k] <= 11'(cv_y[k][YW-1:32]) * 11'(RECIP[37:32]);
      mj_q[k] <= MW'(cv_sum[k][74:44]);
    end
  end

  // Delta arithmetic.
  logic [MW-1:0] cur, rng, thr, prev, ramp;
  logic          wrap, have_n, flag_n;
  logic [MW:0]   delta_n;
  logic [TW:0]   wsum;
  logic [TW-1:0] wt_n;

  logic [MW-1:0] cur_q;
  logic [MW:0]   delta_q;
  logic          have_q, flag_q;
  logic [TW-1:0] wt_q;

  always_comb begin
    cur = mj_q[0];
    rng = mj_q[1];
    thr = rng >> 1;
    prev = entry.last_mj;
    wrap = entry.armed && (cur < thr);
    ramp = (rng > prev) ? rng - prev : '0;
    if (wrap) begin
      delta_n = {1'b0, ramp} + {1'b0, cur};
      have_n = 1'b1;
      flag_n = 1'b0;
      wsum = {1'b0, entry.wrapped_mj} + (TW + 1)'(rng);
    end else begin
      delta_n = (cur > prev) ? {1'b0, cur - prev} : '0;
      have_n = prev != '0;
      flag_n = entry.armed || (cur > thr);
      wsum = {1'b0, entry.wrapped_mj};
    end
    wt_n = wsum[TW] ? '1 : wsum[TW-1:0];
  end

  // Divider for the power.
  logic          div0_start, div0_busy;
  logic [EW-1:0] div0_q;
  logic          calc_go;

  assign calc_go = (state_q == ST_CALC);
  assign div0_start = calc_go && have_n;

  ecpm_div #(.DW(EW), .VW(ecpm_pkg::ELAPSED_W)) u_div0 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div0_start),
    .dividend_i (EW'(delta_n)),
    .divisor_i  (item_q.elapsed_s),
    .busy_o     (div0_busy),
    .quotient_o (div0_q)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
      upd_q <= upd_in;
      dom_ok_q <= dom_ok_in;
    end
    if (calc_go) begin
      cur_q <= cur;
      delta_q <= delta_n;
      have_q <= have_n;
      flag_q <= flag_n;
      wt_q <= wt_n;
    end
  end

  // Final update and result.
  logic [PWR-1:0] pw_n, max_n, min_n;
  logic [TW:0]    tsum;
  logic [TW-1:0]  total_n;
  ecpm_pkg::out_item_t res;

  always_comb begin
    if (have_q) begin
      pw_n = (div0_q[EW-1:PWR] != '0) ? '1 : div0_q[PWR-1:0];
    end else begin
      pw_n = entry.power;
    end
    max_n = (pw_n > entry.pw_max) ? pw_n : entry.pw_max;
    min_n = (entry.pw_min == '0 || pw_n < entry.pw_min) ? pw_n : entry.pw_min;

    wr_entry.last_mj = cur_q;
    wr_entry.wrapped_mj = wt_q;
    wr_entry.armed = flag_q;
    wr_entry.power = pw_n;
    wr_entry.pw_max = max_n;
    wr_entry.pw_min = min_n;

    if (upd_q) begin
      tsum = (TW + 1)'(cur_q) + {1'b0, wt_q};
    end else begin
      tsum = (TW + 1)'(entry.last_mj) + {1'b0, entry.wrapped_mj};
    end
    total_n = tsum[TW] ? '1 : tsum[TW-1:0];

    res.domain_out = item_q.domain;
    res.updated = upd_q;
    if (upd_q) begin
      res.power_mw = pw_n;
      res.max_power_mw = max_n;
      res.min_power_mw = min_n;
      res.energy_total_mj = total_n;
    end else if (dom_ok_q) begin
      res.power_mw = entry.power;
      res.max_power_mw = entry.pw_max;
      res.min_power_mw = entry.pw_min;
      res.energy_total_mj = total_n;
    end else begin
      res.power_mw = '0;
      res.max_power_mw = '0;
      res.min_power_mw = '0;
      res.energy_total_mj = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = upd_q ? ST_CDIV : ST_FIN;
      end
      ST_CDIV: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        state_d = have_n ? ST_PDIV : ST_FIN;
      end
      ST_PDIV: begin
        if (!div0_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_q <= res;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule
